/* hw/rtl/voxel_first_point_filter_defines.svh */
// Assertion macros for the voxel first-point filter checker.
// Included by files that assert; depends on nothing else.
`ifndef VOXEL_FIRST_POINT_FILTER_DEFINES_SVH
`define VOXEL_FIRST_POINT_FILTER_DEFINES_SVH

// Checked only outside reset.
`define VFPF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define VFPF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/vfpf_pkg.sv */
// Shared types, constants and codes of the voxel first-point filter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vfpf_pkg;

   localparam int POS_W      = 28;
   localparam int FIELD_W    = 16;
   localparam int CELL_W     = 21;
   localparam int KEY_PART_W = 21;
   localparam int KEY_W      = 64;
   localparam int DEN_W      = CELL_W + 1;
   localparam int NUM_W      = POS_W + 1;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CELL_W-1:0] MIN_CELL   = CELL_W'(256);
   localparam logic [CELL_W-1:0] CELL_RESET = CELL_W'(1024);
   localparam logic [KEY_W-1:0]  HASH_MULT  = 64'h9E37_79B9_7F4A_7C15;

   localparam int DEFAULT_TABLE_DEPTH = 4096;
   localparam int DEFAULT_MAX_PROBE   = 8;

   localparam logic [CSR_IDX_W-1:0] CFG_CELL_SIZE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CFG_LABEL_MODE = 1'b1;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_HASH,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_READ,
      B_CHECK,
      B_OUT
   } back_state_type;

   // One classified point travelling from front to back.
   typedef struct packed {
      logic                     first_of_scan;
      logic [KEY_W-1:0]         key;
      logic [KEY_W-1:0]         hash;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [POS_W-1:0]  pos_z;
      logic [FIELD_W-1:0]       time_frac;
      logic [FIELD_W-1:0]       intensity;
      logic [FIELD_W-1:0]       label;
   } item_type;

endpackage
`default_nettype wire

/* hw/rtl/voxel_first_point_filter.sv */
// Voxel first-point filter: keeps the first point of every voxel in a scan and
// passes points on in arrival order. Per point, the front end takes an accept
// step, a 29-step restoring divider run on x, y and z side by side, a four-step
// multiply for the hash and a push step that waits while the queue is full.
// The back end takes the low hash bits as the slot, so TABLE_DEPTH must be a
// power of two; it pops the point, then probes the table with a read step and a
// check step per probe (one read port, registered read data), up to MAX_PROBE
// probes, and loads the output register for a point that it passes on.
// The two halves overlap through a two-entry queue, so the front end can take
// a new point while the back end is still busy with the last one.
// After reset the table is swept clear, and req_ready stays low until the
// sweep is done; a point with first_of_scan set costs the same sweep in the
// back end before it is looked up.
// Configuration (csr_*) must only be written while the block is idle.
// Depends on vfpf_pkg, vfpf_front, vfpf_queue, vfpf_back, vfpf_ram.
`timescale 1ns / 1ps
`default_nettype none
module voxel_first_point_filter #(
   parameter int TABLE_DEPTH = vfpf_pkg::DEFAULT_TABLE_DEPTH,
   parameter int MAX_PROBE   = vfpf_pkg::DEFAULT_MAX_PROBE
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration write port
   input  logic                              csr_we,
   input  logic [vfpf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [vfpf_pkg::CELL_W-1:0]       csr_wdata,
   // point input beats
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_first_of_scan,
   input  logic signed [vfpf_pkg::POS_W-1:0] req_pos_x,
   input  logic signed [vfpf_pkg::POS_W-1:0] req_pos_y,
   input  logic signed [vfpf_pkg::POS_W-1:0] req_pos_z,
   input  logic [vfpf_pkg::FIELD_W-1:0]      req_time_frac,
   input  logic [vfpf_pkg::FIELD_W-1:0]      req_intensity,
   input  logic [vfpf_pkg::FIELD_W-1:0]      req_label,
   // kept-point output beats
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [vfpf_pkg::POS_W-1:0] rsp_out_x,
   output logic signed [vfpf_pkg::POS_W-1:0] rsp_out_y,
   output logic signed [vfpf_pkg::POS_W-1:0] rsp_out_z,
   output logic [vfpf_pkg::FIELD_W-1:0]      rsp_out_time_frac,
   output logic [vfpf_pkg::FIELD_W-1:0]      rsp_out_intensity,
   output logic [vfpf_pkg::FIELD_W-1:0]      rsp_out_label,
   output logic                              rsp_overflow
);
   import vfpf_pkg::*;

   logic [CELL_W-1:0] cell_size_ff;
   logic              label_mode_ff;

   logic     init_done;
   logic     push, pop, queue_full, queue_empty;
   item_type push_item, head;

   // config registers; cell_size below 256 is clamped in the front end
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff  <= CELL_RESET;
         label_mode_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CFG_CELL_SIZE:  cell_size_ff  <= csr_wdata;
            CFG_LABEL_MODE: label_mode_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // front: key = trunc(pos / edge) per axis (edge halved or doubled by label mode), then hash
   vfpf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cell_size        (cell_size_ff),
      .label_mode       (label_mode_ff),
      .init_done        (init_done),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_first_of_scan(req_first_of_scan),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_time_frac    (req_time_frac),
      .req_intensity    (req_intensity),
      .req_label        (req_label),
      .push             (push),
      .push_item        (push_item),
      .queue_full       (queue_full)
   );

   vfpf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_item(push_item),
      .full     (queue_full),
      .pop      (pop),
      .head     (head),
      .empty    (queue_empty)
   );

   // back: table clear, slot select, linear probe, output register
   vfpf_back #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .MAX_PROBE  (MAX_PROBE)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .init_done        (init_done),
      .head             (head),
      .queue_empty      (queue_empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_out_z        (rsp_out_z),
      .rsp_out_time_frac(rsp_out_time_frac),
      .rsp_out_intensity(rsp_out_intensity),
      .rsp_out_label    (rsp_out_label),
      .rsp_overflow     (rsp_overflow)
   );

endmodule
`default_nettype wire

/* hw/rtl/vfpf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module vfpf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hw/rtl/vfpf_front.sv */
// Front end: takes a point, divides x/y/z by the cell edge and hashes the key.
// Depends on vfpf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vfpf_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [vfpf_pkg::CELL_W-1:0]          cell_size,
   input  logic                                 label_mode,
   input  logic                                 init_done,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_first_of_scan,
   input  logic signed [vfpf_pkg::POS_W-1:0]    req_pos_x,
   input  logic signed [vfpf_pkg::POS_W-1:0]    req_pos_y,
   input  logic signed [vfpf_pkg::POS_W-1:0]    req_pos_z,
   input  logic [vfpf_pkg::FIELD_W-1:0]         req_time_frac,
   input  logic [vfpf_pkg::FIELD_W-1:0]         req_intensity,
   input  logic [vfpf_pkg::FIELD_W-1:0]         req_label,
   output logic                                 push,
   output vfpf_pkg::item_type                   push_item,
   input  logic                                 queue_full
);
   import vfpf_pkg::*;

   localparam int STEP_W = $clog2(NUM_W);

   front_state_type state_ff, state_in;
   logic [NUM_W-1:0]   num_ff [3];
   logic [NUM_W-1:0]   num_in [3];
   logic [DEN_W:0]     rem_ff [3];
   logic [DEN_W:0]     rem_in [3];
   logic [2:0]         neg_ff, neg_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [1:0]         chunk_ff, chunk_in;
   logic [KEY_W-1:0]   kshift_ff, kshift_in;
   logic [KEY_W-1:0]   acc_ff, acc_in;
   item_type           item_ff, item_in;

   logic                    accept;
   logic [CELL_W-1:0]       cell_eff;
   logic                    fine, coarse;
   logic [POS_W-1:0]        pos [3];
   logic [POS_W-1:0]        mag;
   logic [DEN_W:0]          trial;
   logic [KEY_PART_W-1:0]   part [3];
   logic [KEY_W-1:0]        prod;

   assign req_ready = (state_ff == F_IDLE) && init_done;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      neg_ff    <= neg_in;
      den_ff    <= den_in;
      step_ff   <= step_in;
      chunk_ff  <= chunk_in;
      kshift_ff <= kshift_in;
      acc_ff    <= acc_in;
      item_ff   <= item_in;
   end

   always_comb begin
      state_in  = state_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      neg_in    = neg_ff;
      den_in    = den_ff;
      step_in   = step_ff;
      chunk_in  = chunk_ff;
      kshift_in = kshift_ff;
      acc_in    = acc_ff;
      item_in   = item_ff;
      push      = 1'b0;
      push_item = item_ff;
      cell_eff  = (cell_size < MIN_CELL) ? MIN_CELL : cell_size;
      fine      = label_mode && (req_label != '0);
      coarse    = label_mode && (req_label == '0);
      pos[0]    = req_pos_x;
      pos[1]    = req_pos_y;
      pos[2]    = req_pos_z;
      mag       = '0;
      trial     = '0;
      prod      = '0;
      for (int i = 0; i < 3; i++) begin
         part[i] = '0;
      end

      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               den_in = coarse ? {cell_eff, 1'b0} : {1'b0, cell_eff};
               for (int i = 0; i < 3; i++) begin
                  neg_in[i] = pos[i][POS_W-1];
                  mag       = neg_in[i] ? (~pos[i] + POS_W'(1)) : pos[i];
                  num_in[i] = fine ? {mag, 1'b0} : {1'b0, mag};
                  rem_in[i] = '0;
               end
               step_in                = '0;
               item_in.first_of_scan  = req_first_of_scan;
               item_in.pos_x          = req_pos_x;
               item_in.pos_y          = req_pos_y;
               item_in.pos_z          = req_pos_z;
               item_in.time_frac      = req_time_frac;
               item_in.intensity      = req_intensity;
               item_in.label          = req_label;
               state_in               = F_DIV;
            end
         end
         F_DIV: begin
            // restoring division, one quotient bit per lane per cycle
            for (int i = 0; i < 3; i++) begin
               trial = {rem_ff[i][DEN_W-1:0], num_ff[i][NUM_W-1]};
               if (trial >= {1'b0, den_ff}) begin
                  rem_in[i] = trial - {1'b0, den_ff};
                  num_in[i] = {num_ff[i][NUM_W-2:0], 1'b1};
               end else begin
                  rem_in[i] = trial;
                  num_in[i] = {num_ff[i][NUM_W-2:0], 1'b0};
               end
               part[i] = neg_ff[i] ? (KEY_PART_W'(0) - num_in[i][KEY_PART_W-1:0])
                                   : num_in[i][KEY_PART_W-1:0];
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(NUM_W - 1)) begin
               item_in.key = {1'b1, part[0], part[1], part[2]};
               kshift_in   = {1'b1, part[0], part[1], part[2]};
               acc_in      = '0;
               chunk_in    = '0;
               state_in    = F_HASH;
            end
         end
         F_HASH: begin
            // Horner form of key * HASH_MULT, 16 key bits per cycle
            prod      = {48'd0, kshift_ff[KEY_W-1 -: 16]} * HASH_MULT;
            acc_in    = (acc_ff << 16) + prod;
            kshift_in = kshift_ff << 16;
            chunk_in  = chunk_ff + 2'd1;
            if (chunk_ff == 2'd3) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            push_item.hash = acc_ff ^ (acc_ff >> 29);
            if (!queue_full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

/* hw/rtl/vfpf_queue.sv */
// Two-entry queue of classified points between front and back.
// Depends on vfpf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vfpf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  vfpf_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output vfpf_pkg::item_type head,
   output logic               empty
);
   import vfpf_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/vfpf_back.sv */
// Back end: takes the low hash bits as the slot, probes the seen-voxel table,
// drives results. Depends on vfpf_pkg and vfpf_ram.
`timescale 1ns / 1ps
`default_nettype none
module vfpf_back #(
   parameter int TABLE_DEPTH = vfpf_pkg::DEFAULT_TABLE_DEPTH,
   parameter int MAX_PROBE   = vfpf_pkg::DEFAULT_MAX_PROBE
) (
   input  logic                              clock,
   input  logic                              reset,
   output logic                              init_done,
   input  vfpf_pkg::item_type                head,
   input  logic                              queue_empty,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [vfpf_pkg::POS_W-1:0] rsp_out_x,
   output logic signed [vfpf_pkg::POS_W-1:0] rsp_out_y,
   output logic signed [vfpf_pkg::POS_W-1:0] rsp_out_z,
   output logic [vfpf_pkg::FIELD_W-1:0]      rsp_out_time_frac,
   output logic [vfpf_pkg::FIELD_W-1:0]      rsp_out_intensity,
   output logic [vfpf_pkg::FIELD_W-1:0]      rsp_out_label,
   output logic                              rsp_overflow
);
   import vfpf_pkg::*;

   // TABLE_DEPTH is a power of two: hash mod depth is the low AW bits
   localparam int AW      = $clog2(TABLE_DEPTH);
   localparam int PW      = $clog2(MAX_PROBE + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

   back_state_type state_ff, state_in;
   logic              init_done_ff, init_done_in;
   item_type          cur_ff, cur_in;
   logic [AW-1:0]     clear_ff, clear_in;
   logic [AW-1:0]     slot_ff, slot_in;
   logic [PW-1:0]     probe_ff, probe_in;
   logic              ovf_ff, ovf_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_load;
   logic signed [POS_W-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic [FIELD_W-1:0]      out_time_ff, out_int_ff, out_label_ff;
   logic                    out_ovf_ff;

   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr;
   logic [KEY_W-1:0]  wr_data, rd_data;

   vfpf_ram #(
      .WIDTH(KEY_W),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(slot_ff),
      .rd_data(rd_data)
   );

   assign init_done = init_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         init_done_ff <= 1'b0;
         clear_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_done_ff <= init_done_in;
         clear_ff     <= clear_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff     <= cur_in;
      slot_ff    <= slot_in;
      probe_ff   <= probe_in;
      ovf_ff     <= ovf_in;
      if (rsp_load) begin
         out_x_ff     <= cur_ff.pos_x;
         out_y_ff     <= cur_ff.pos_y;
         out_z_ff     <= cur_ff.pos_z;
         out_time_ff  <= cur_ff.time_frac;
         out_int_ff   <= cur_ff.intensity;
         out_label_ff <= cur_ff.label;
         out_ovf_ff   <= ovf_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      init_done_in = init_done_ff;
      cur_in       = cur_ff;
      clear_in     = clear_ff;
      slot_in      = slot_ff;
      probe_in     = probe_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_load     = 1'b0;
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = slot_ff;
      wr_data      = cur_ff.key;
      rd_en        = 1'b0;

      case (state_ff)
         B_CLEAR: begin
            wr_en    = 1'b1;
            wr_addr  = clear_ff;
            wr_data  = '0;
            clear_in = clear_ff + AW'(1);
            if (clear_ff == LAST_SLOT) begin
               clear_in     = '0;
               init_done_in = 1'b1;
               slot_in      = cur_ff.hash[AW-1:0];
               probe_in     = '0;
               state_in     = init_done_ff ? B_READ : B_IDLE;
            end
         end
         B_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               cur_in   = head;
               slot_in  = head.hash[AW-1:0];
               probe_in = '0;
               state_in = head.first_of_scan ? B_CLEAR : B_READ;
            end
         end
         B_READ: begin
            rd_en    = 1'b1;
            state_in = B_CHECK;
         end
         B_CHECK: begin
            if (rd_data == cur_ff.key) begin
               state_in = B_IDLE;
            end else if (!rd_data[KEY_W-1]) begin
               wr_en    = 1'b1;
               ovf_in   = 1'b0;
               state_in = B_OUT;
            end else if (probe_ff == PW'(MAX_PROBE - 1)) begin
               ovf_in   = 1'b1;
               state_in = B_OUT;
            end else begin
               probe_in = probe_ff + PW'(1);
               slot_in  = (slot_ff == LAST_SLOT) ? '0 : slot_ff + AW'(1);
               state_in = B_READ;
            end
         end
         B_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_x         = out_x_ff;
   assign rsp_out_y         = out_y_ff;
   assign rsp_out_z         = out_z_ff;
   assign rsp_out_time_frac = out_time_ff;
   assign rsp_out_intensity = out_int_ff;
   assign rsp_out_label     = out_label_ff;
   assign rsp_overflow      = out_ovf_ff;

endmodule
`default_nettype wire

/* hw/rtl/vfpf_checker.sv */
// Port-level checks for the voxel first-point filter, bound to the top level.
// Depends on vfpf_pkg and voxel_first_point_filter_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "voxel_first_point_filter_defines.svh"
module vfpf_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [vfpf_pkg::POS_W-1:0] rsp_out_x,
   input logic                              rsp_overflow
);
   import vfpf_pkg::*;

   `VFPF_ASSERT(rsp_held, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp beat dropped")
   `VFPF_ASSERT(rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_out_x) && $stable(rsp_overflow), "rsp payload moved")
   `VFPF_ASSERT_ALWAYS(no_rsp_after_reset, clock, reset |=> !rsp_valid, "rsp valid right after reset")
   `VFPF_ASSERT_ALWAYS(sweep_blocks_req, clock, reset |=> !req_ready, "req taken during clear sweep")

endmodule

bind voxel_first_point_filter vfpf_checker u_vfpf_checker (.*);
`default_nettype wire
